// ----- design/ststab_pkg.sv -----
// Shared types, constants and codes of the sorted tab stop table.
package ststab_pkg;

  localparam int MAX_STOPS     = 32;
  localparam int POSITION_BITS = 16;

  localparam int IDX_W = $clog2(MAX_STOPS);
  localparam int CNT_W = $clog2(MAX_STOPS + 1);

  localparam int STOP_STEP  = 36;
  localparam int STOP_LIMIT = 720;

  // Fixed field widths of the stream beats.
  localparam int KIND_W      = 4;
  localparam int IN_POS_W    = 16;
  localparam int STATUS_W    = 3;
  localparam int COUNT_W     = 6;
  localparam int PREV_IDX_W  = 6;
  localparam int OUT_POS_W   = 16;
  localparam int ALIGN_W     = 3;
  localparam int OUT_DATA_W  = 40;

  typedef enum logic [KIND_W-1:0] {
    KIND_SET_LEFT   = 4'd0,
    KIND_SET_RIGHT  = 4'd1,
    KIND_SET_CENTER = 4'd2,
    KIND_SET_BETW   = 4'd3,
    KIND_SET_CHAR   = 4'd4,
    KIND_DIVIDE     = 4'd5,
    KIND_CLEAR_ONE  = 4'd6,
    KIND_CLEAR_ALL  = 4'd7,
    KIND_LOOKUP     = 4'd8
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_REPLACED  = 3'd1,
    ST_UNCHANGED = 3'd2,
    ST_DELETED   = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_CLEARED   = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic find;
    logic apply;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  // Number of stops loaded at reset.
  function automatic int reset_total();
    int n;
    n = 0;
    for (int x = STOP_STEP; x < STOP_LIMIT; x += STOP_STEP) begin
      if (n < MAX_STOPS && longint'(x) <= ((longint'(1) << POSITION_BITS) - 1)) begin
        n++;
      end
    end
    return n;
  endfunction

  localparam int RESET_TOTAL = reset_total();

endpackage

// ----- design/ststab_ctrl.sv -----
// Controller state machine of the sorted tab stop table.
module ststab_ctrl import ststab_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t dp_stat,
  output cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_APPLY,
    S_FIND2,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  logic   take;

  // A new beat may enter while the previous result is being loaded out.
  assign in_ready = (state == S_IDLE) || (state == S_EMIT && dp_stat.out_free);
  assign take     = in_valid && in_ready;

  always_comb begin
    cmd.load_in  = take;
    cmd.find     = (state == S_FIND) || (state == S_FIND2);
    cmd.apply    = (state == S_APPLY);
    cmd.load_out = (state == S_EMIT) && dp_stat.out_free;
    state_next   = state;
    case (state)
      S_IDLE: begin
        if (take) state_next = S_FIND;
      end
      S_FIND:  state_next = S_APPLY;
      S_APPLY: state_next = S_FIND2;
      S_FIND2: state_next = S_EMIT;
      S_EMIT: begin
        if (take) begin
          state_next = S_FIND;
        end else if (dp_stat.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- design/ststab_dpath.sv -----
// Datapath of the sorted tab stop table: stop cells, compare row and result register.
module ststab_dpath import ststab_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output dp_stat_t              dp_stat,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [IN_POS_W-1:0]   in_position,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_DATA_W-1:0] out_data
);

  logic [KIND_W-1:0]        kind_q;
  logic [POSITION_BITS-1:0] pos_q;
  logic [POSITION_BITS-1:0] stop_pos   [MAX_STOPS];
  logic [ALIGN_W-1:0]       stop_align [MAX_STOPS];
  logic [CNT_W-1:0]         total;
  logic [MAX_STOPS-1:0]     le_vec;
  logic [STATUS_W-1:0]      status_q;

  logic [POSITION_BITS-1:0] stop_pos_next   [MAX_STOPS];
  logic [ALIGN_W-1:0]       stop_align_next [MAX_STOPS];
  logic [CNT_W-1:0]         total_next;
  logic [STATUS_W-1:0]      status_next;
  logic [MAX_STOPS-1:0]     le_next;

  logic                     any;
  logic [IDX_W-1:0]         idx;
  logic                     hit;
  logic [CNT_W-1:0]         slot;
  logic [PREV_IDX_W-1:0]    prev_index;
  logic [OUT_POS_W-1:0]     prev_position;
  logic [ALIGN_W-1:0]       prev_alignment;

  assign dp_stat.out_free = !out_valid || out_ready;

  // Compare row: one comparator per cell, valid cells only.
  always_comb begin
    for (int j = 0; j < MAX_STOPS; j++) begin
      le_next[j] = (CNT_W'(j) < total) && (stop_pos[j] <= pos_q);
    end
  end

  // The row is a thermometer code since the table is sorted; take its top bit.
  always_comb begin
    any = |le_vec;
    idx = '0;
    for (int j = 0; j < MAX_STOPS; j++) begin
      if (le_vec[j]) idx = IDX_W'(j);
    end
  end

  assign hit  = any && (stop_pos[idx] == pos_q);
  assign slot = any ? CNT_W'(idx) + CNT_W'(1) : '0;

  always_comb begin
    stop_pos_next   = stop_pos;
    stop_align_next = stop_align;
    total_next      = total;
    status_next     = ST_UNCHANGED;
    if (kind_q <= KIND_SET_CHAR) begin
      if (hit) begin
        if (stop_align[idx] != ALIGN_W'(kind_q)) begin
          stop_align_next[idx] = ALIGN_W'(kind_q);
          status_next          = ST_REPLACED;
        end
      end else if (total == CNT_W'(MAX_STOPS)) begin
        status_next = ST_FULL;
      end else begin
        for (int j = 1; j < MAX_STOPS; j++) begin
          if (CNT_W'(j) > slot) begin
            stop_pos_next[j]   = stop_pos[j-1];
            stop_align_next[j] = stop_align[j-1];
          end
        end
        for (int j = 0; j < MAX_STOPS; j++) begin
          if (CNT_W'(j) == slot) begin
            stop_pos_next[j]   = pos_q;
            stop_align_next[j] = ALIGN_W'(kind_q);
          end
        end
        total_next  = total + CNT_W'(1);
        status_next = ST_INSERTED;
      end
    end else if (kind_q == KIND_DIVIDE || kind_q == KIND_CLEAR_ALL) begin
      total_next  = '0;
      status_next = ST_CLEARED;
    end else if (kind_q == KIND_CLEAR_ONE) begin
      if (hit) begin
        for (int j = 0; j < MAX_STOPS - 1; j++) begin
          if (IDX_W'(j) >= idx) begin
            stop_pos_next[j]   = stop_pos[j+1];
            stop_align_next[j] = stop_align[j+1];
          end
        end
        total_next  = total - CNT_W'(1);
        status_next = ST_DELETED;
      end else begin
        status_next = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_q <= in_kind;
      pos_q  <= in_position[POSITION_BITS-1:0];
    end
    if (cmd.find) begin
      le_vec <= le_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_STOPS; j++) begin
        stop_pos[j]   <= (j < RESET_TOTAL) ? POSITION_BITS'(STOP_STEP * (j + 1)) : '0;
        stop_align[j] <= '0;
      end
      total    <= CNT_W'(RESET_TOTAL);
      status_q <= ST_UNCHANGED;
    end else if (cmd.apply) begin
      stop_pos   <= stop_pos_next;
      stop_align <= stop_align_next;
      total      <= total_next;
      status_q   <= status_next;
    end
  end

  assign prev_index     = any ? PREV_IDX_W'(idx) : '1;
  assign prev_position  = any ? OUT_POS_W'(stop_pos[idx]) : '0;
  assign prev_alignment = any ? stop_align[idx] : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {6'd0, prev_alignment, prev_position, prev_index,
                   COUNT_W'(total), status_q};
    end
  end

endmodule

// ----- design/sorted_tab_stop_table_top.sv -----
// Top level of the sorted tab stop table.
//
// The block keeps a table of up to 32 tab stops sorted by position, each with
// an alignment code. Commands arrive on the slave stream: s_tuser carries the
// kind (set a stop with an alignment, divide, clear one, clear all or lookup)
// and s_tdata the position. Every command beat gives exactly one result beat
// on the master stream with a status, the stop count after the command and
// the last stop at or before the position, looked up in the updated table.
// A command passes through four steps in order: compare all cells against the
// position, apply the edit (a shift of part of the row by at most one cell),
// compare again, and load the result register. A new command is taken in the
// cycle the previous result is loaded, so it never enters before that step.
// The sequencing state machine walks through the four steps in that order.
// If the receiver stalls, the result waits in the output register and one
// further command may run up to its last step, then the block holds s_tready
// low until the result is taken. Synchronous reset loads 19 left-aligned
// stops at 36, 72 and so on up to 684, and empties the output register.
module sorted_tab_stop_table_top import ststab_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // position[15:0]
  input  logic [3:0]  s_tuser,   // kind[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // status[2:0], stop_count[8:3], prev_index[14:9], prev_position[30:15],
  // prev_alignment[33:31], zero fill[39:34]
  output logic [39:0] m_tdata
);

  cmd_t     cmd;
  dp_stat_t dp_stat;

  ststab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .dp_stat  (dp_stat),
    .cmd      (cmd)
  );

  ststab_dpath u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .dp_stat     (dp_stat),
    .in_kind     (s_tuser),
    .in_position (s_tdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (m_tdata)
  );

endmodule
